// ===== rtl/tte_pkg.sv =====
package tte_pkg;

  localparam int TAP_DEPTH     = 4;
  localparam int CNT_W         = $clog2(TAP_DEPTH + 1);
  localparam int IDX_W         = $clog2(TAP_DEPTH);
  localparam int TIME_W        = 32;
  localparam int FRAC_BITS     = 8;
  localparam int MS_PER_MINUTE = 60000;
  localparam longint NUM_MAX   = longint'(MS_PER_MINUTE) * (TAP_DEPTH - 1) * (2 ** FRAC_BITS);
  localparam int NUM_W         = $clog2(NUM_MAX + 1);
  localparam int STEP_W        = $clog2(NUM_W);
  localparam int BPM_W         = 10;
  localparam int IDLE_W        = 16;
  localparam int TEMPO_W       = 18;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_BPM  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BPM  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_GAP = 2'd2;

  localparam logic [BPM_W-1:0]  MIN_BPM_RST  = 10'd80;
  localparam logic [BPM_W-1:0]  MAX_BPM_RST  = 10'd300;
  localparam logic [IDLE_W-1:0] IDLE_GAP_RST = 16'd2000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_OUT
  } tte_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/tte_if.sv =====
interface tte_tap_if;
  logic                        valid;
  logic                        ready;
  logic [tte_pkg::TIME_W-1:0]  tap_time_ms;

  modport source (output valid, output tap_time_ms, input ready);
  modport sink   (input valid, input tap_time_ms, output ready);
endinterface

interface tte_tempo_if;
  logic                        valid;
  logic                        ready;
  logic                        tempo_valid;
  logic [tte_pkg::TEMPO_W-1:0] tempo_q8;

  modport source (output valid, output tempo_valid, output tempo_q8, input ready);
  modport sink   (input valid, input tempo_valid, input tempo_q8, output ready);
endinterface

interface tte_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tte_pkg::CFG_IDX_W-1:0]  index;
  logic [tte_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/tte_divider.sv =====
module tte_divider (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [tte_pkg::NUM_W-1:0]  dividend_i,
  input  logic [tte_pkg::TIME_W-1:0] divisor_i,
  output tte_pkg::div_stat_t         stat_o,
  output logic [tte_pkg::NUM_W-1:0]  quotient_o
);

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [tte_pkg::STEP_W-1:0]  cnt_q, cnt_d;
  logic [tte_pkg::TIME_W-1:0]  rem_q, rem_d;
  logic [tte_pkg::NUM_W-1:0]   quot_q, quot_d;
  logic [tte_pkg::TIME_W-1:0]  div_q, div_d;
  logic [tte_pkg::TIME_W:0]    trial;
  logic                        fits;

  always_comb begin
    trial  = {rem_q, quot_q[tte_pkg::NUM_W-1]};
    fits   = (trial >= {1'b0, div_q});
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    div_d  = div_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = tte_pkg::STEP_W'(tte_pkg::NUM_W - 1);
      rem_d  = '0;
      quot_d = dividend_i;
      div_d  = divisor_i;
    end else if (busy_q) begin
      rem_d  = fits ? tte_pkg::TIME_W'(trial - {1'b0, div_q}) : trial[tte_pkg::TIME_W-1:0];
      quot_d = {quot_q[tte_pkg::NUM_W-2:0], fits};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    div_q  <= div_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quot_q;

endmodule

// ===== rtl/tap_tempo_estimator_unit.sv =====
// Tap tempo estimator. Each word on the tap channel is one tap with a free-running millisecond
// timestamp; the last four taps are kept, and every tap yields exactly one result word that
// carries the tempo 60000*(n-1)/span in Q10.8 bpm, truncated and clamped to the min/max bpm
// registers, or tempo_valid low when fewer than two taps are held, the span is shorter than the
// interval count, or the latest gap exceeds idle_gap_ms (which restarts the history from this
// tap). A tap that yields a tempo passes through the restoring divider, which produces one
// quotient bit per cycle over a 26-bit dividend; any other tap skips the divider. The tap
// channel is not ready while a tap is in work; a finished result waits in an output register,
// so the next tap is taken while that word is still pending. Configuration writes are always
// ready and take effect at once.
module tap_tempo_estimator_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  tte_tap_if.sink            tap_i,
  tte_tempo_if.source        tempo_o,
  tte_cfg_if.sink            cfg_i
);

  tte_pkg::tte_state_e state_q, state_d;

  logic [tte_pkg::BPM_W-1:0]   min_bpm_q, max_bpm_q;
  logic [tte_pkg::IDLE_W-1:0]  idle_gap_q;
  logic [tte_pkg::TIME_W-1:0]  hist_q [tte_pkg::TAP_DEPTH];
  logic [tte_pkg::CNT_W-1:0]   held_q;
  logic [tte_pkg::TIME_W-1:0]  now_q;
  logic                        res_tv_q;
  logic [tte_pkg::TEMPO_W-1:0] res_tq_q;
  logic                        out_valid_q;
  logic                        out_tv_q;
  logic [tte_pkg::TEMPO_W-1:0] out_tq_q;

  logic                        tap_acc;
  logic                        out_free;
  logic                        div_start;
  logic                        restart;
  logic                        load_zero;
  logic                        load_tempo;
  logic [tte_pkg::CNT_W-1:0]   intervals;
  logic [tte_pkg::IDX_W-1:0]   prev_idx;
  logic [tte_pkg::TIME_W-1:0]  span;
  logic [tte_pkg::TIME_W-1:0]  gap;
  logic [tte_pkg::NUM_W-1:0]   num_base;
  logic [tte_pkg::NUM_W-1:0]   dividend;
  logic [tte_pkg::NUM_W-1:0]   quotient;
  logic [tte_pkg::NUM_W-1:0]   lo_bound, hi_bound, lo_clamped, clamped;
  tte_pkg::div_stat_t          div_stat;

  assign tap_i.ready = (state_q == tte_pkg::ST_IDLE);
  assign tap_acc     = tap_i.valid && tap_i.ready;
  assign cfg_i.ready = 1'b1;
  assign out_free    = !out_valid_q || tempo_o.ready;

  assign intervals = held_q - tte_pkg::CNT_W'(1);
  assign prev_idx  = tte_pkg::IDX_W'(held_q - tte_pkg::CNT_W'(2));
  assign span      = now_q - hist_q[0];
  assign gap       = now_q - hist_q[prev_idx];
  assign num_base  = tte_pkg::NUM_W'(tte_pkg::MS_PER_MINUTE) * tte_pkg::NUM_W'(intervals);
  assign dividend  = num_base << tte_pkg::FRAC_BITS;

  assign lo_bound   = tte_pkg::NUM_W'({min_bpm_q, tte_pkg::FRAC_BITS'(0)});
  assign hi_bound   = tte_pkg::NUM_W'({max_bpm_q, tte_pkg::FRAC_BITS'(0)});
  assign lo_clamped = (quotient < lo_bound) ? lo_bound : quotient;
  assign clamped    = (lo_clamped > hi_bound) ? hi_bound : lo_clamped;

  tte_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (span),
    .stat_o     (div_stat),
    .quotient_o (quotient)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tte_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    div_start  = 1'b0;
    restart    = 1'b0;
    load_zero  = 1'b0;
    load_tempo = 1'b0;
    case (state_q)
      tte_pkg::ST_IDLE: begin
        if (tap_acc) begin
          state_d = tte_pkg::ST_EVAL;
        end
      end
      tte_pkg::ST_EVAL: begin
        if (held_q < tte_pkg::CNT_W'(2) || span < tte_pkg::TIME_W'(intervals)) begin
          load_zero = 1'b1;
          state_d   = tte_pkg::ST_OUT;
        end else if (gap > tte_pkg::TIME_W'(idle_gap_q)) begin
          restart   = 1'b1;
          load_zero = 1'b1;
          state_d   = tte_pkg::ST_OUT;
        end else begin
          div_start = 1'b1;
          state_d   = tte_pkg::ST_DIV;
        end
      end
      tte_pkg::ST_DIV: begin
        if (div_stat.done) begin
          load_tempo = 1'b1;
          state_d    = tte_pkg::ST_OUT;
        end
      end
      tte_pkg::ST_OUT: begin
        if (out_free) begin
          state_d = tte_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tte_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_bpm_q  <= tte_pkg::MIN_BPM_RST;
      max_bpm_q  <= tte_pkg::MAX_BPM_RST;
      idle_gap_q <= tte_pkg::IDLE_GAP_RST;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        tte_pkg::CFG_MIN_BPM:  min_bpm_q  <= cfg_i.data[tte_pkg::BPM_W-1:0];
        tte_pkg::CFG_MAX_BPM:  max_bpm_q  <= cfg_i.data[tte_pkg::BPM_W-1:0];
        tte_pkg::CFG_IDLE_GAP: idle_gap_q <= cfg_i.data[tte_pkg::IDLE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
    end else if (tap_acc) begin
      if (held_q >= tte_pkg::CNT_W'(tte_pkg::TAP_DEPTH)) begin
        held_q <= tte_pkg::CNT_W'(tte_pkg::TAP_DEPTH);
      end else begin
        held_q <= held_q + tte_pkg::CNT_W'(1);
      end
    end else if (restart) begin
      held_q <= tte_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (tap_acc) begin
      now_q <= tap_i.tap_time_ms;
      if (held_q >= tte_pkg::CNT_W'(tte_pkg::TAP_DEPTH)) begin
        for (int i = 0; i < tte_pkg::TAP_DEPTH - 1; i++) begin
          hist_q[i] <= hist_q[i+1];
        end
        hist_q[tte_pkg::TAP_DEPTH-1] <= tap_i.tap_time_ms;
      end else begin
        hist_q[tte_pkg::IDX_W'(held_q)] <= tap_i.tap_time_ms;
      end
    end else if (restart) begin
      hist_q[0] <= now_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_zero) begin
      res_tv_q <= 1'b0;
      res_tq_q <= '0;
    end else if (load_tempo) begin
      res_tv_q <= 1'b1;
      res_tq_q <= clamped[tte_pkg::TEMPO_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == tte_pkg::ST_OUT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (tempo_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == tte_pkg::ST_OUT && out_free) begin
      out_tv_q <= res_tv_q;
      out_tq_q <= res_tq_q;
    end
  end

  assign tempo_o.valid       = out_valid_q;
  assign tempo_o.tempo_valid = out_tv_q;
  assign tempo_o.tempo_q8    = out_tq_q;

endmodule
